[rtl/tppe_pkg.sv]
package tppe_pkg;

    localparam int MAX_FRAME_BYTES = 65535;
    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (OFF_W + 1 > 8) ? OFF_W + 1 : 8;

    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_FRAME_BYTES);

    localparam logic [15:0] DEFAULT_PORT   = 16'd443;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

    localparam logic [CMP_W-1:0] OFF_ETH_HI   = CMP_W'(12);
    localparam logic [CMP_W-1:0] OFF_ETH_LO   = CMP_W'(13);
    localparam logic [CMP_W-1:0] OFF_IHL      = CMP_W'(14);
    localparam logic [CMP_W-1:0] OFF_PROTO    = CMP_W'(23);
    localparam logic [CMP_W-1:0] OFF_SRC_FROM = CMP_W'(26);
    localparam logic [CMP_W-1:0] OFF_SRC_TO   = CMP_W'(29);
    localparam logic [CMP_W-1:0] IP_BASE      = CMP_W'(14);
    localparam logic [CMP_W-1:0] TCP_DOFF     = CMP_W'(12);

    typedef struct packed {
        logic [15:0] src_port;
        logic [31:0] source_address;
        logic        end_of_packet;
        logic        byte_valid;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

[rtl/tcp_port_payload_extractor.sv]
// a result is registered into the output entry, or into the skid entry while the output entry is held
// throughput: one byte per cycle, sustained; ready drops only while the skid entry is full
// frames that fail a check or end before the payload start give no result
// reset (rst_n low, asynchronous) clears all frame state and both output entries
// and sets the matched source port to 443
module tcp_port_payload_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // frame_byte
    input  logic        s_axis_tlast,   // frame_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // payload_byte, source_address, src_port
    output logic        m_axis_tlast,   // end_of_packet
    output logic        m_axis_tuser    // byte_valid
);
    import tppe_pkg::*;

    logic [15:0]      match_port_reg;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [7:0]       eth_hi_reg, eth_hi_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [3:0]       thl_reg, thl_next;
    logic [31:0]      addr_reg, addr_next;
    logic [15:0]      port_reg, port_next;
    logic             rejected_reg, rejected_next;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          out_reg, out_next;
    result_t          skid_reg, skid_next;

    logic             accept;
    logic             produce;
    logic [CMP_W-1:0] off_c;
    logic [CMP_W-1:0] tcp_start;
    logic [CMP_W-1:0] pay_start;
    logic             hit_valid;
    logic             hit_end;
    logic             rej;
    result_t          res;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign off_c     = CMP_W'(offset_reg);
    assign tcp_start = IP_BASE + CMP_W'({ihl_reg, 2'b00});
    assign pay_start = tcp_start + CMP_W'({thl_reg, 2'b00});

    always_comb
    begin
        eth_hi_next = eth_hi_reg;
        ihl_next    = ihl_reg;
        thl_next    = thl_reg;
        addr_next   = addr_reg;
        port_next   = port_reg;
        rej         = rejected_reg;
        hit_valid   = 1'b0;
        hit_end     = 1'b0;
        if (!rejected_reg)
        begin
            if (offset_reg >= OFF_LIMIT)
            begin
                rej = 1'b1;
            end
            else
            begin
                if (off_c == OFF_ETH_HI)
                begin
                    eth_hi_next = s_axis_tdata;
                end
                if (off_c == OFF_ETH_LO && {eth_hi_reg, s_axis_tdata} != ETHERTYPE_IPV4)
                begin
                    rej = 1'b1;
                end
                if (off_c == OFF_IHL)
                begin
                    ihl_next = s_axis_tdata[3:0];
                    if (s_axis_tdata[3:0] < MIN_HDR_WORDS)
                    begin
                        rej = 1'b1;
                    end
                end
                if (off_c == OFF_PROTO && s_axis_tdata != PROTO_TCP)
                begin
                    rej = 1'b1;
                end
                if (off_c >= OFF_SRC_FROM && off_c <= OFF_SRC_TO)
                begin
                    addr_next = {addr_reg[23:0], s_axis_tdata};
                end
                if (!rej && ihl_reg >= MIN_HDR_WORDS)
                begin
                    if (off_c == tcp_start)
                    begin
                        port_next = {s_axis_tdata, 8'h00};
                    end
                    if (off_c == tcp_start + CMP_W'(1))
                    begin
                        port_next = {port_reg[15:8], s_axis_tdata};
                        if ({port_reg[15:8], s_axis_tdata} != match_port_reg)
                        begin
                            rej = 1'b1;
                        end
                    end
                    if (off_c == tcp_start + TCP_DOFF)
                    begin
                        thl_next = s_axis_tdata[7:4];
                        if (s_axis_tdata[7:4] < MIN_HDR_WORDS)
                        begin
                            rej = 1'b1;
                        end
                    end
                    if (!rej && thl_reg != 4'd0)
                    begin
                        hit_valid = (off_c >= pay_start);
                        hit_end   = s_axis_tlast && (off_c + CMP_W'(1) >= pay_start);
                    end
                end
            end
        end
        rejected_next = rej;
    end

    always_comb
    begin
        res.payload_byte   = hit_valid ? s_axis_tdata : 8'h00;
        res.byte_valid     = hit_valid;
        res.end_of_packet  = hit_end;
        res.source_address = addr_reg;
        res.src_port       = port_reg;
    end

    assign produce = accept && (hit_valid || hit_end);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = produce;
                out_next       = res;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_comb
    begin
        offset_next = offset_reg;
        if (offset_reg < OFF_LIMIT)
        begin
            offset_next = offset_reg + OFF_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_port_reg <= DEFAULT_PORT;
        end
        else if (cfg_we)
        begin
            match_port_reg <= cfg_wdata;
        end
    end

    // frame state, cleared after the last byte of every frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            eth_hi_reg   <= '0;
            ihl_reg      <= '0;
            thl_reg      <= '0;
            addr_reg     <= '0;
            port_reg     <= '0;
            rejected_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                offset_reg   <= '0;
                eth_hi_reg   <= '0;
                ihl_reg      <= '0;
                thl_reg      <= '0;
                addr_reg     <= '0;
                port_reg     <= '0;
                rejected_reg <= 1'b0;
            end
            else
            begin
                offset_reg   <= offset_next;
                eth_hi_reg   <= eth_hi_next;
                ihl_reg      <= ihl_next;
                thl_reg      <= thl_next;
                addr_reg     <= addr_next;
                port_reg     <= port_next;
                rejected_reg <= rejected_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.src_port, out_reg.source_address, out_reg.payload_byte};
    assign m_axis_tlast  = out_reg.end_of_packet;
    assign m_axis_tuser  = out_reg.byte_valid;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output entry empty");

    a_rise_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without an input transfer");

    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
        else $error("result with no payload byte is not a frame end");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> offset_reg == '0 && !rejected_reg)
        else $error("frame state not cleared after last byte");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import tppe_pkg::*;

    localparam int SETTLE_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SHOWN_MISMATCHES = 20;

    typedef enum logic [1:0] {STEP_BYTE, STEP_DRAIN, STEP_PORT} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic [15:0] value;
        logic        is_last;
    } stream_step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // frame_byte
    logic        s_axis_tlast = 1'b0;  // frame_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // payload_byte, source_address, src_port
    logic        m_axis_tlast;         // end_of_packet
    logic        m_axis_tuser;         // byte_valid

    stream_step_t frame_stream[$];
    result_t      expected_payload[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           sent_bytes = 0;

    // predictor state
    logic [15:0] want_port;
    logic [15:0] frame_pos;
    logic [15:0] eth_seen;
    logic [3:0]  ihl_seen;
    logic [31:0] addr_seen;
    logic [15:0] port_seen;
    logic [3:0]  doff_seen;
    logic        frame_dropped;

    // sender state
    int   burst_left;
    int   gap_left;
    int   settle_left;
    logic next_valid;
    logic next_we;
    logic offer_pending = 1'b0;

    // receiver state
    int         rx_left;
    int         rx_tick;
    logic [1:0] rx_mode;
    logic       rx_ready;
    result_t    want;

    tcp_port_payload_extractor DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic flag_error(input string field, input logic [63:0] exp_val,
                              input logic [63:0] got_val);
        if (mismatches < SHOWN_MISMATCHES)
            $display("mismatch on %s: expected %0h, got %0h", field, exp_val, got_val);
        mismatches++;
    endtask

    task automatic clear_frame_state();
        frame_pos = '0;
        eth_seen = '0;
        ihl_seen = '0;
        addr_seen = '0;
        port_seen = '0;
        doff_seen = '0;
        frame_dropped = 1'b0;
    endtask

    task automatic track_frame_byte(input logic [7:0] b, input logic is_last);
        int unsigned off;
        int unsigned tcp_at;
        int unsigned data_at;
        logic hit_byte;
        logic hit_end;
        result_t r;
        off = 32'(frame_pos);
        hit_byte = 1'b0;
        hit_end = 1'b0;
        if (!frame_dropped)
        begin
            if (off >= MAX_FRAME_BYTES)
                frame_dropped = 1'b1;
            else
            begin
                if (off == OFF_ETH_HI)
                    eth_seen = {b, 8'h00};
                if (off == OFF_ETH_LO)
                begin
                    eth_seen[7:0] = b;
                    if (eth_seen != ETHERTYPE_IPV4)
                        frame_dropped = 1'b1;
                end
                if (off == OFF_IHL)
                begin
                    ihl_seen = b[3:0];
                    if (ihl_seen < MIN_HDR_WORDS)
                        frame_dropped = 1'b1;
                end
                if (off == OFF_PROTO && b != PROTO_TCP)
                    frame_dropped = 1'b1;
                if (off >= OFF_SRC_FROM && off <= OFF_SRC_TO)
                    addr_seen = {addr_seen[23:0], b};
                if (!frame_dropped && ihl_seen >= MIN_HDR_WORDS)
                begin
                    tcp_at = IP_BASE + 4 * ihl_seen;
                    if (off == tcp_at)
                        port_seen = {b, 8'h00};
                    if (off == tcp_at + 1)
                    begin
                        port_seen[7:0] = b;
                        if (port_seen != want_port)
                            frame_dropped = 1'b1;
                    end
                    if (off == tcp_at + TCP_DOFF)
                    begin
                        doff_seen = b[7:4];
                        if (doff_seen < MIN_HDR_WORDS)
                            frame_dropped = 1'b1;
                    end
                    if (!frame_dropped && doff_seen != 0)
                    begin
                        data_at = tcp_at + 4 * doff_seen;
                        hit_byte = (off >= data_at);
                        hit_end = is_last && (off + 1 >= data_at);
                    end
                end
            end
        end
        if (hit_byte || hit_end)
        begin
            r.payload_byte = hit_byte ? b : 8'h00;
            r.byte_valid = hit_byte;
            r.end_of_packet = hit_end;
            r.source_address = addr_seen;
            r.src_port = port_seen;
            expected_payload.push_back(r);
        end
        if (is_last)
            clear_frame_state();
        else if (off < 16'hFFFF)
            frame_pos = 16'(off + 1);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic is_last);
        frame_stream.push_back('{STEP_BYTE, {8'h00, b}, is_last});
        sent_bytes++;
    endtask

    task automatic push_drain();
        frame_stream.push_back('{STEP_DRAIN, 16'h0000, 1'b0});
    endtask

    task automatic push_port(input logic [15:0] port);
        push_drain();
        frame_stream.push_back('{STEP_PORT, port, 1'b0});
    endtask

    // keep > 0 cuts the frame to that many bytes
    task automatic push_frame(input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [15:0] sport,
                              input logic [3:0] doff, input int paylen, input int keep);
        logic [7:0] f[$];
        int ip_len;
        int tcp_len;
        ip_len = (ihl < MIN_HDR_WORDS) ? 20 : 4 * ihl;
        tcp_len = (doff < MIN_HDR_WORDS) ? 20 : 4 * doff;
        repeat (12) f.push_back(8'($urandom));
        f.push_back(etype[15:8]);
        f.push_back(etype[7:0]);
        f.push_back({4'($urandom), ihl});
        repeat (8) f.push_back(8'($urandom));
        f.push_back(proto);
        repeat (ip_len - 10) f.push_back(8'($urandom));
        f.push_back(sport[15:8]);
        f.push_back(sport[7:0]);
        repeat (10) f.push_back(8'($urandom));
        f.push_back({doff, 4'($urandom)});
        repeat (tcp_len - 13 + paylen) f.push_back(8'($urandom));
        if (keep > 0)
            while (f.size() > keep)
                void'(f.pop_back());
        foreach (f[i])
            push_byte(f[i], i == f.size() - 1);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            cfg_we <= 1'b0;
            cfg_wdata <= '0;
            burst_left = 0;
            gap_left = 0;
            settle_left = 0;
            offer_pending = 1'b0;
            want_port = DEFAULT_PORT;
            clear_frame_state();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                track_frame_byte(s_axis_tdata, s_axis_tlast);
            next_valid = s_axis_tvalid && !s_axis_tready;
            next_we = 1'b0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (settle_left > 0)
                    settle_left--;
                else if (frame_stream.size() > 0)
                begin
                    case (frame_stream[0].kind)
                        STEP_BYTE:
                        begin
                            s_axis_tdata <= frame_stream[0].value[7:0];
                            s_axis_tlast <= frame_stream[0].is_last;
                            next_valid = 1'b1;
                            void'(frame_stream.pop_front());
                            if (burst_left > 0)
                                burst_left--;
                            else
                            begin
                                burst_left = ($urandom_range(4, 0) == 0) ?
                                             $urandom_range(300, 50) : $urandom_range(30, 1);
                                gap_left = ($urandom_range(3, 0) == 0) ?
                                           0 : $urandom_range(10, 1);
                            end
                        end
                        STEP_DRAIN:
                        begin
                            if (expected_payload.size() == 0)
                            begin
                                void'(frame_stream.pop_front());
                                settle_left = SETTLE_CYCLES;
                            end
                        end
                        default:
                        begin
                            next_we = 1'b1;
                            cfg_wdata <= frame_stream[0].value;
                            want_port = frame_stream[0].value;
                            void'(frame_stream.pop_front());
                        end
                    endcase
                end
            end
            offer_pending = next_valid;
            s_axis_tvalid <= next_valid;
            cfg_we <= next_we;
        end
    end

    // receiver and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_left = 0;
            rx_tick = 0;
            rx_mode = '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_payload.size() == 0)
                    flag_error("unexpected transfer", 64'h0, 64'(m_axis_tdata));
                else
                begin
                    want = expected_payload.pop_front();
                    if (m_axis_tdata[7:0] !== want.payload_byte)
                        flag_error("payload_byte", 64'(want.payload_byte),
                                   64'(m_axis_tdata[7:0]));
                    if (m_axis_tuser !== want.byte_valid)
                        flag_error("byte_valid", 64'(want.byte_valid), 64'(m_axis_tuser));
                    if (m_axis_tlast !== want.end_of_packet)
                        flag_error("end_of_packet", 64'(want.end_of_packet),
                                   64'(m_axis_tlast));
                    if (m_axis_tdata[39:8] !== want.source_address)
                        flag_error("source_address", 64'(want.source_address),
                                   64'(m_axis_tdata[39:8]));
                    if (m_axis_tdata[55:40] !== want.src_port)
                        flag_error("src_port", 64'(want.src_port),
                                   64'(m_axis_tdata[55:40]));
                end
            end
            rx_tick++;
            if (rx_left == 0)
            begin
                rx_mode = 2'($urandom_range(3, 0));
                rx_left = $urandom_range(200, 30);
            end
            else
                rx_left--;
            case (rx_mode)
                2'd0: rx_ready = 1'b1;
                2'd1: rx_ready = ($urandom_range(3, 0) != 0);
                2'd2: rx_ready = (rx_tick % 7) >= 3;
                default: rx_ready = (rx_tick % 20) < 6;
            endcase
            m_axis_tready <= rx_ready;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tcp_port_payload_extractor test failed");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int paylen;
        int whole;
        int since_port;
        logic [3:0] ihl;
        logic [3:0] doff;
        logic [15:0] plan_port;

        // directed frames, port at its reset value
        plan_port = DEFAULT_PORT;
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port, 4'd5, 3, 0);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port, 4'd5, 0, 0);
        push_frame(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, plan_port, 4'd15, 2, 0);
        push_frame(16'h0801, 4'd5, PROTO_TCP, plan_port, 4'd5, 2, 0);
        push_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, plan_port, 4'd5, 2, 0);
        push_frame(ETHERTYPE_IPV4, 4'd5, 8'd17, plan_port, 4'd5, 2, 0);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port + 16'd1, 4'd5, 2, 0);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port, 4'd4, 2, 0);
        // early ends: one byte short of the payload start, mid header, single byte
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port, 4'd5, 4, 53);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port, 4'd5, 4, 30);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port, 4'd5, 4, 1);
        // cut right at the first payload byte
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, plan_port, 4'd5, 4, 55);

        plan_port = 16'h0000;
        push_port(plan_port);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd5, 4, 0);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0001, 4'd5, 4, 0);

        plan_port = 16'hFFFF;
        push_port(plan_port);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'hFFFF, 4'd5, 1, 0);
        push_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'hFFFE, 4'd5, 1, 0);

        // random frames
        since_port = 0;
        while (sent_bytes < 1050)
        begin
            if (since_port > 350)
            begin
                case ($urandom_range(3, 0))
                    0: plan_port = 16'h0000;
                    1: plan_port = 16'hFFFF;
                    default: plan_port = 16'($urandom);
                endcase
                push_port(plan_port);
                since_port = 0;
            end
            else if ($urandom_range(40, 0) == 0)
                push_drain();
            ihl = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 5)) : MIN_HDR_WORDS;
            doff = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 5)) : MIN_HDR_WORDS;
            paylen = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 0) : $urandom_range(12, 0);
            whole = 14 + 4 * ihl + 4 * doff + paylen;
            kind = $urandom_range(99, 0);
            if (kind < 70)
            begin
                push_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP, plan_port, doff, paylen, 0);
                since_port += whole;
            end
            else if (kind < 76)
                push_frame(ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(15, 0)), ihl, PROTO_TCP,
                           plan_port, doff, paylen, 0);
            else if (kind < 80)
                push_frame(ETHERTYPE_IPV4, 4'($urandom_range(4, 0)), PROTO_TCP, plan_port,
                           doff, paylen, 0);
            else if (kind < 85)
                push_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP ^ (8'd1 << $urandom_range(7, 0)),
                           plan_port, doff, paylen, 0);
            else if (kind < 90)
                push_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP,
                           plan_port ^ (16'd1 << $urandom_range(15, 0)), doff, paylen, 0);
            else if (kind < 93)
                push_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP, plan_port,
                           4'($urandom_range(4, 0)), paylen, 0);
            else if (kind < 97)
                push_frame(ETHERTYPE_IPV4, ihl, PROTO_TCP, plan_port, doff, paylen,
                           $urandom_range(whole - 1, 1));
            else
            begin
                whole = $urandom_range(60, 1);
                for (int i = 0; i < whole; i++)
                    push_byte(8'($urandom), i == whole - 1);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (frame_stream.size() != 0 || offer_pending || expected_payload.size() != 0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_payload.size() == 0)
            $display("tcp_port_payload_extractor test passed");
        else
            $display("tcp_port_payload_extractor test failed");
        $finish;
    end

endmodule

[files.f]
rtl/tppe_pkg.sv
rtl/tcp_port_payload_extractor.sv
sim/tb_top.sv
